/* rtl/dtid_pkg.sv */
// Shared types and constants for the dual timer and I/O interrupt device.
package dtid_pkg;

  // Item command codes.
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Register map.
  localparam logic [3:0] REG_PRA   = 4'd0;
  localparam logic [3:0] REG_PRB   = 4'd1;
  localparam logic [3:0] REG_DIR_A = 4'd2;
  localparam logic [3:0] REG_DIR_B = 4'd3;
  localparam logic [3:0] REG_TA_LO = 4'd4;
  localparam logic [3:0] REG_TA_HI = 4'd5;
  localparam logic [3:0] REG_TB_LO = 4'd6;
  localparam logic [3:0] REG_TB_HI = 4'd7;
  localparam logic [3:0] REG_TOD0  = 4'd8;
  localparam logic [3:0] REG_TOD1  = 4'd9;
  localparam logic [3:0] REG_TOD2  = 4'd10;
  localparam logic [3:0] REG_TOD3  = 4'd11;
  localparam logic [3:0] REG_SDR   = 4'd12;
  localparam logic [3:0] REG_ICR   = 4'd13;
  localparam logic [3:0] REG_CRA   = 4'd14;
  localparam logic [3:0] REG_CRB   = 4'd15;

  // Control register bit positions.
  localparam int CTRL_START   = 0;
  localparam int CTRL_ONESHOT = 3;
  localparam int CTRL_LOAD    = 4;

  // Timer B count source modes (control bits 6:5).
  localparam logic [1:0] TB_MODE_CLOCK = 2'b00;

  // Interrupt source width and set/clear bit of the interrupt control write.
  localparam int INT_W      = 5;
  localparam int ICR_SET    = 7;

  // One decoded item as held in the input register.
  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  addr;
    logic [7:0]  wdata;
    logic [7:0]  pins_a;
    logic [7:0]  pins_b;
  } op_t;

  // Write strobes for one timer.
  typedef struct packed {
    logic lo;
    logic hi;
    logic ctrl;
  } tmr_wr_t;

endpackage

/* rtl/dual_timer_io_interrupt_device.sv */
// Top level: input register, register file and timers, result register.
//
// Each item is a register read, a register write or one timer tick. The block
// takes one item per clock unless stalled: an item is captured in the input
// register, acts on the state as it moves into the result register, and its
// result is offered from there. The input register and the result register
// let a new item be taken while a result still waits; only a stalled result
// that also blocks the input register holds in_ready low. Reads return the
// state before the item, and out_irq shows the interrupt line after the item.
module dual_timer_io_interrupt_device
  import dtid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_port_a_pins,
  input  logic [7:0] in_port_b_pins,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq
);

  logic       s1_valid_r;
  op_t        s1_op_r;
  logic       out_valid_r;
  logic [7:0] out_read_data_r;
  logic       out_irq_r;
  logic       adv, exec;
  logic [7:0] core_rd;
  logic       core_irq;

  // Handshake: the input register moves on whenever the result register is free.
  assign adv      = !out_valid_r || out_ready;
  assign exec     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r.cmd    <= cmd_t'(in_command);
      s1_op_r.addr   <= in_reg_addr;
      s1_op_r.wdata  <= in_write_data;
      s1_op_r.pins_a <= in_port_a_pins;
      s1_op_r.pins_b <= in_port_b_pins;
    end
  end

  dtid_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .exec    (exec),
    .op      (s1_op_r),
    .rd_data (core_rd),
    .irq     (core_irq)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_read_data_r <= core_rd;
      out_irq_r       <= core_irq;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq       = out_irq_r;

  // Only read items produce nonzero read data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (s1_op_r.cmd != CMD_READ)) |=> (out_read_data_r == 8'd0))
    else $error("non-read item returned nonzero read data");

  // Reading the interrupt register clears pending, so the line drops.
  assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (s1_op_r.cmd == CMD_READ) && (s1_op_r.addr == REG_ICR)) |=> !out_irq_r)
    else $error("irq still set after interrupt register read");

  // A full input register behind a stalled result blocks new items.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are blocked");

  // An item leaving the input register always appears as a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed item did not produce a result");

endmodule

/* rtl/dtid_timer.sv */
// One 16-bit down-counting timer with reload latch and control byte.
module dtid_timer
  import dtid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tmr_wr_t     wr,
  input  logic [7:0]  wdata,
  input  logic        cnt_en,
  output logic [15:0] count,
  output logic [7:0]  ctrl,
  output logic        underflow
);

  logic [15:0] reload_r, reload_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  load_clr;

  assign load_clr  = ~(8'd1 << CTRL_LOAD);
  assign underflow = cnt_en && ctrl_r[CTRL_START] && (count_r == 16'd0);

  // Next state: register writes and counting never happen in the same item.
  always_comb begin
    reload_nxt = reload_r;
    count_nxt  = count_r;
    ctrl_nxt   = ctrl_r;
    if (wr.lo) begin
      reload_nxt = {reload_r[15:8], wdata};
    end
    if (wr.hi) begin
      reload_nxt = {wdata, reload_r[7:0]};
      if (!ctrl_r[CTRL_START]) begin
        count_nxt = {wdata, reload_r[7:0]};
      end
    end
    if (wr.ctrl) begin
      if (wdata[CTRL_LOAD]) begin
        count_nxt = reload_r;
      end
      ctrl_nxt = wdata & load_clr;
    end
    if (cnt_en && ctrl_r[CTRL_START]) begin
      if (underflow) begin
        count_nxt = reload_r;
        if (ctrl_r[CTRL_ONESHOT]) begin
          ctrl_nxt[CTRL_START] = 1'b0;
        end
      end else begin
        count_nxt = count_r - 16'd1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= '0;
      count_r  <= '0;
      ctrl_r   <= '0;
    end else begin
      reload_r <= reload_nxt;
      count_r  <= count_nxt;
      ctrl_r   <= ctrl_nxt;
    end
  end

  assign count = count_r;
  assign ctrl  = ctrl_r;

endmodule

/* rtl/dtid_core.sv */
// Register file, ports, interrupt logic and the two timers.
module dtid_core
  import dtid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       exec,
  input  op_t        op,
  output logic [7:0] rd_data,
  output logic       irq
);

  logic             do_rd, do_wr, do_tick;
  tmr_wr_t          a_wr, b_wr;
  logic [15:0]      a_count, b_count;
  logic [7:0]       a_ctrl, b_ctrl;
  logic             a_under, b_under, b_en;
  logic [7:0]       pra_r, prb_r, ddra_r, ddrb_r, sdr_r;
  logic [7:0]       tod_r [4];
  logic [INT_W-1:0] pend_r, pend_nxt, mask_r, mask_nxt;
  logic [7:0]       rd_mux;

  // Command decode.
  assign do_rd   = exec && (op.cmd == CMD_READ);
  assign do_wr   = exec && (op.cmd == CMD_WRITE);
  assign do_tick = exec && (op.cmd == CMD_TICK);

  assign a_wr.lo   = do_wr && (op.addr == REG_TA_LO);
  assign a_wr.hi   = do_wr && (op.addr == REG_TA_HI);
  assign a_wr.ctrl = do_wr && (op.addr == REG_CRA);
  assign b_wr.lo   = do_wr && (op.addr == REG_TB_LO);
  assign b_wr.hi   = do_wr && (op.addr == REG_TB_HI);
  assign b_wr.ctrl = do_wr && (op.addr == REG_CRB);

  // Timer B counts every tick or on a Timer A underflow; the CNT mode never counts.
  assign b_en = do_tick && ((b_ctrl[6:5] == TB_MODE_CLOCK) || (b_ctrl[6] && a_under));

  dtid_timer u_tmr_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (a_wr),
    .wdata     (op.wdata),
    .cnt_en    (do_tick),
    .count     (a_count),
    .ctrl      (a_ctrl),
    .underflow (a_under)
  );

  dtid_timer u_tmr_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (b_wr),
    .wdata     (op.wdata),
    .cnt_en    (b_en),
    .count     (b_count),
    .ctrl      (b_ctrl),
    .underflow (b_under)
  );

  // Interrupt pending and mask; a read of the interrupt register clears pending.
  always_comb begin
    pend_nxt = pend_r | {3'b000, b_under, a_under};
    if (do_rd && (op.addr == REG_ICR)) begin
      pend_nxt = '0;
    end
    mask_nxt = mask_r;
    if (do_wr && (op.addr == REG_ICR)) begin
      if (op.wdata[ICR_SET]) begin
        mask_nxt = mask_r | op.wdata[INT_W-1:0];
      end else begin
        mask_nxt = mask_r & ~op.wdata[INT_W-1:0];
      end
    end
  end

  assign irq = |(pend_nxt & mask_nxt);

  // Plain storage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pra_r  <= '0;
      prb_r  <= '0;
      ddra_r <= '0;
      ddrb_r <= '0;
      sdr_r  <= '0;
      pend_r <= '0;
      mask_r <= '0;
      for (int i = 0; i < 4; i++) begin
        tod_r[i] <= '0;
      end
    end else begin
      pend_r <= pend_nxt;
      mask_r <= mask_nxt;
      if (do_wr) begin
        unique case (op.addr)
          REG_PRA:   pra_r  <= op.wdata;
          REG_PRB:   prb_r  <= op.wdata;
          REG_DIR_A: ddra_r <= op.wdata;
          REG_DIR_B: ddrb_r <= op.wdata;
          REG_TOD0, REG_TOD1, REG_TOD2, REG_TOD3: tod_r[op.addr[1:0]] <= op.wdata;
          REG_SDR:   sdr_r  <= op.wdata;
          default: ;
        endcase
      end
    end
  end

  // Read multiplexer over the state before this item.
  always_comb begin
    unique case (op.addr)
      REG_PRA:   rd_mux = (pra_r & ddra_r) | (op.pins_a & ~ddra_r);
      REG_PRB:   rd_mux = (prb_r & ddrb_r) | (op.pins_b & ~ddrb_r);
      REG_DIR_A: rd_mux = ddra_r;
      REG_DIR_B: rd_mux = ddrb_r;
      REG_TA_LO: rd_mux = a_count[7:0];
      REG_TA_HI: rd_mux = a_count[15:8];
      REG_TB_LO: rd_mux = b_count[7:0];
      REG_TB_HI: rd_mux = b_count[15:8];
      REG_TOD0, REG_TOD1, REG_TOD2, REG_TOD3: rd_mux = tod_r[op.addr[1:0]];
      REG_SDR:   rd_mux = sdr_r;
      REG_ICR:   rd_mux = {|(pend_r & mask_r), 2'b00, pend_r};
      REG_CRA:   rd_mux = a_ctrl;
      default:   rd_mux = b_ctrl;
    endcase
  end

  assign rd_data = do_rd ? rd_mux : 8'd0;

endmodule
